// File: rtl/rgb_text_command_parser_unit_macros.svh
// Assertion macros used by the RGB command parser top module.
`ifndef RGB_TEXT_COMMAND_PARSER_UNIT_MACROS_SVH
`define RGB_TEXT_COMMAND_PARSER_UNIT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define RGBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next.
`define RGBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rgbp_pkg.sv
// Types and constants for the RGB text command parser.
package rgbp_pkg;

  // Maximum line length in bytes, including the terminator slot.
  localparam int unsigned LineCap = 32;
  localparam int unsigned LineCntW = $clog2(LineCap);

  localparam logic [15:0] SaveDelayReset = 16'd2000;
  localparam logic [15:0] ElapsedMax = 16'hFFFF;

  // Character codes used by the parser.
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  // Channel values after reset.
  localparam logic [7:0] RedReset = 8'd255;
  localparam logic [7:0] GreenReset = 8'd0;
  localparam logic [7:0] BlueReset = 8'd0;
  localparam logic [7:0] ChannelMax = 8'd255;
  localparam logic [8:0] AccumSat = 9'd256;

  // Action codes of an input item.
  localparam logic ActByte = 1'b0;
  localparam logic ActTick = 1'b1;

  // Which number of the triple is being read, or the outcome of the line.
  typedef enum logic [2:0] {
    PhNum0,
    PhNum1,
    PhNum2,
    PhDone,
    PhFail
  } rgbp_phase_e;

  // Progress within one number.
  typedef enum logic [1:0] {
    StSpace,
    StSign,
    StDigits
  } rgbp_stage_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } rgbp_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       color_changed;
    logic       save_request;
  } rgbp_out_t;

  // Color after one item, as handed from the parser to the top level.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       changed;
  } rgbp_color_t;

  // Whitespace as the scan format defines it.
  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

// File: rtl/rgbp_line_parser.sv
// Byte-at-a-time parser of "%d,%d,%d" lines holding the stored color.
module rgbp_line_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  rgbp_pkg::rgbp_in_t   item_i,
  output rgbp_pkg::rgbp_color_t color_o
);
  import rgbp_pkg::*;

  logic [LineCntW-1:0] line_cnt_q, line_cnt_d;
  rgbp_phase_e         phase_q, phase_d;
  rgbp_stage_e         stage_q, stage_d;
  logic                neg_q, neg_d;
  logic [8:0]          accum_q, accum_d;
  logic [7:0]          first_q, first_d;
  logic [7:0]          second_q, second_d;
  logic [7:0]          red_q, red_d;
  logic [7:0]          green_q, green_d;
  logic [7:0]          blue_q, blue_d;
  logic                changed;

  logic [7:0]  c;
  logic        is_digit;
  logic [11:0] acc_x10;
  logic [7:0]  clamped;
  logic        triple_ok;

  assign c = item_i.rx_byte;
  assign is_digit = (c >= ChZero) && (c <= ChNine);

  // Accumulate one decimal digit; the lower nibble of an ASCII digit is its value.
  assign acc_x10 = {accum_q, 3'b000} + {2'b00, accum_q, 1'b0} + {8'h00, c[3:0]};

  // Clamp the current number to a channel value.
  assign clamped = neg_q ? 8'd0 : (accum_q[8] ? ChannelMax : accum_q[7:0]);

  assign triple_ok = ((phase_q == PhNum2) && (stage_q == StDigits)) || (phase_q == PhDone);

  // Next parse state and color for the item in hand.
  always_comb begin
    line_cnt_d = line_cnt_q;
    phase_d    = phase_q;
    stage_d    = stage_q;
    neg_d      = neg_q;
    accum_d    = accum_q;
    first_d    = first_q;
    second_d   = second_q;
    red_d      = red_q;
    green_d    = green_q;
    blue_d     = blue_q;
    changed    = 1'b0;

    if (step_i && (item_i.action == ActByte)) begin
      if (c == ChLf) begin
        // End of line: take the triple if complete, then start over.
        if (triple_ok) begin
          red_d   = first_q;
          green_d = second_q;
          blue_d  = clamped;
          changed = 1'b1;
        end
        line_cnt_d = '0;
        phase_d    = PhNum0;
        stage_d    = StSpace;
        neg_d      = 1'b0;
        accum_d    = '0;
      end else if (line_cnt_q < LineCntW'(LineCap - 1)) begin
        line_cnt_d = line_cnt_q + LineCntW'(1);
        // Feed the byte unless the line is already finished or failed.
        if ((phase_q == PhNum0) || (phase_q == PhNum1) || (phase_q == PhNum2)) begin
          priority if (is_digit) begin
            accum_d = (acc_x10 > 12'(AccumSat)) ? AccumSat : acc_x10[8:0];
            stage_d = StDigits;
          end else if ((stage_q == StSpace) && is_space(c)) begin
            // Leading whitespace is skipped.
          end else if ((stage_q == StSpace) && ((c == ChPlus) || (c == ChMinus))) begin
            neg_d   = (c == ChMinus);
            stage_d = StSign;
          end else if ((stage_q == StDigits) && (phase_q != PhNum2) && (c == ChComma)) begin
            if (phase_q == PhNum0) begin
              first_d = clamped;
              phase_d = PhNum1;
            end else begin
              second_d = clamped;
              phase_d  = PhNum2;
            end
            stage_d = StSpace;
            neg_d   = 1'b0;
            accum_d = '0;
          end else if ((stage_q == StDigits) && (phase_q == PhNum2)) begin
            // Anything after the third number is ignored.
            phase_d = PhDone;
          end else begin
            phase_d = PhFail;
          end
        end
      end else begin
        // Overlong line: drop the byte and restart the parse.
        line_cnt_d = '0;
        phase_d    = PhNum0;
        stage_d    = StSpace;
        neg_d      = 1'b0;
        accum_d    = '0;
      end
    end
  end

  // Parser and color registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cnt_q <= '0;
      phase_q    <= PhNum0;
      stage_q    <= StSpace;
      neg_q      <= 1'b0;
      accum_q    <= '0;
      first_q    <= '0;
      second_q   <= '0;
      red_q      <= RedReset;
      green_q    <= GreenReset;
      blue_q     <= BlueReset;
    end else begin
      line_cnt_q <= line_cnt_d;
      phase_q    <= phase_d;
      stage_q    <= stage_d;
      neg_q      <= neg_d;
      accum_q    <= accum_d;
      first_q    <= first_d;
      second_q   <= second_d;
      red_q      <= red_d;
      green_q    <= green_d;
      blue_q     <= blue_d;
    end
  end

  assign color_o.red     = red_d;
  assign color_o.green   = green_d;
  assign color_o.blue    = blue_d;
  assign color_o.changed = changed;

endmodule

// File: rtl/rgb_text_command_parser_unit.sv
// RGB text command parser: byte and tick input, color and save-request output.
//
// Input items carry either a received serial byte (action 0) or a one
// millisecond tick (action 1). Bytes are parsed as lines of the form
// "r,g,b"; a newline that completes a valid triple updates the stored color
// and sets color_changed. Every input item produces exactly one result item
// with the current color and a save_request flag, which fires once
// save_delay_ms ticks have passed after the last accepted color.
// The configuration channel writes save_delay_ms; it is always ready and
// should only be written while the block is idle.
// The result for an item is registered in the output register, or in the skid
// entry while a result waits. Throughput: one item per cycle while in_ready_o is
// high; the parser and timer logic do the parse, clamp and timer update combinationally.
// The output side has a result register plus one skid entry, so one more
// item is taken while a result waits; when both hold results, in_ready_o
// drops until the receiver takes one.
// Reset sets the color to red (255,0,0), clears the line parse and the save
// timer, and loads save_delay_ms with 2000.
`include "rgb_text_command_parser_unit_macros.svh"

module rgb_text_command_parser_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rgbp_pkg::rgbp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rgbp_pkg::rgbp_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import rgbp_pkg::*;

  logic        push, pop;
  rgbp_color_t color;
  rgbp_out_t   res_d;

  logic [15:0] save_delay_q;
  logic [15:0] elapsed_q, elapsed_d;
  logic        pending_q, pending_d, pending_nx;
  logic        fire;

  rgbp_out_t   main_q, skid_q;
  logic        main_valid_q, skid_valid_q;

  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign in_ready_o  = !skid_valid_q;
  assign cfg_ready_o = 1'b1;

  rgbp_line_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (push),
    .item_i  (in_data_i),
    .color_o (color)
  );

  // Save timer: counts ticks since the last accepted color.
  always_comb begin
    elapsed_d  = elapsed_q;
    pending_nx = pending_q;
    if (push) begin
      if (color.changed) begin
        elapsed_d  = '0;
        pending_nx = 1'b1;
      end else if ((in_data_i.action == ActTick) && (elapsed_q != ElapsedMax)) begin
        elapsed_d = elapsed_q + 16'd1;
      end
    end
    fire      = push && pending_nx && (elapsed_d >= save_delay_q);
    pending_d = pending_nx && !fire;
  end

  // Result item for the accepted input.
  always_comb begin
    res_d.red           = color.red;
    res_d.green         = color.green;
    res_d.blue          = color.blue;
    res_d.color_changed = color.changed;
    res_d.save_request  = fire;
  end

  // Configuration register and timer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      save_delay_q <= SaveDelayReset;
      elapsed_q    <= '0;
      pending_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        save_delay_q <= cfg_data_i;
      end
      elapsed_q <= elapsed_d;
      pending_q <= pending_d;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || pop) begin
      main_valid_q <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output payload moves along with the valid flags above.
  always_ff @(posedge clk_i) begin
    if (!main_valid_q || pop) begin
      main_q <= skid_valid_q ? skid_q : res_d;
    end else if (push) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  // The skid entry is only used behind a held result.
  `RGBP_ASSERT(a_skid_behind_main, !skid_valid_q || main_valid_q, "skid entry without result")
  // A stalled input always means the output side is full.
  `RGBP_ASSERT(a_stall_only_when_full, in_ready_o || out_valid_o, "input stalled with room")
  // A fired save clears the pending request.
  `RGBP_ASSERT_NEXT(a_fire_clears, push && fire, !pending_q, "save fired but still pending")
  // A new color either fires at once or leaves a save pending.
  `RGBP_ASSERT_NEXT(a_change_arms, push && color.changed && !fire, pending_q && (elapsed_q == 16'd0),
    "color change did not arm save")

endmodule
